// File: design/pfa_pkg.sv
package pfa_pkg;

	localparam int MAX_PARTS_DEF = 16;
	localparam int SIZE_BITS_DEF = 16;
	localparam int TOTAL_RESET = 640;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	localparam logic [0:0] REG_POLICY = 1'b0;
	localparam logic [0:0] REG_TOTAL = 1'b1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_BAD_SIZE = 3'd1,
		ST_NO_SPACE = 3'd2,
		ST_BAD_INDEX = 3'd3,
		ST_TABLE_FULL = 3'd4
	} status_t;

	typedef struct packed {
		logic operation;
		logic [15:0] request_size;
		logic [3:0] partition_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [15:0] start_address;
		logic [3:0] placed_index;
	} out_item_t;

	typedef struct packed {
		logic cfg_reset;
		logic start_scan;
		logic step_scan;
		logic shift_up;
		logic shift_down;
		logic merge_next;
		logic merge_prev;
		logic mark_pick;
		logic clear_busy;
		logic finish_split;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic found;
		logic exact;
		logic full;
		logic shift_done;
		logic idx_bad;
		logic next_free;
		logic prev_free;
	} dp_stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT_UP,
		S_SPLIT,
		S_FREE_CHK,
		S_MERGE_NEXT,
		S_SHIFT_DN1,
		S_MERGE_PREV_CHK,
		S_MERGE_PREV,
		S_SHIFT_DN2,
		S_OUT
	} state_t;

endpackage

// File: design/pfa_datapath.sv
module pfa_datapath #(
	parameter int MAX_PARTS = 16,
	parameter int SIZE_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input pfa_pkg::dp_cmd_t cmd,
	input pfa_pkg::in_item_t item,
	input logic [1:0] policy,
	input logic [15:0] total,
	output pfa_pkg::dp_stat_t stat,
	output logic [SIZE_BITS-1:0] pick_start,
	output logic [$clog2(MAX_PARTS)-1:0] pick_idx
);
	import pfa_pkg::*;

	localparam int IW = $clog2(MAX_PARTS);
	localparam int CW = $clog2(MAX_PARTS + 1);

	logic [SIZE_BITS-1:0] start_q [MAX_PARTS];
	logic [SIZE_BITS-1:0] size_q [MAX_PARTS];
	logic [MAX_PARTS-1:0] busy_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] scan_q;
	logic [IW-1:0] pick_q;
	logic [CW-1:0] pos_q;
	logic found_q;
	logic [SIZE_BITS-1:0] req;
	logic [IW-1:0] sidx;
	logic cand;
	logic [CW-1:0] fidx;

	assign req = SIZE_BITS'(item.request_size);
	assign sidx = scan_q[IW-1:0];
	assign fidx = CW'(item.partition_index);
	assign cand = (scan_q < count_q) && !busy_q[sidx] && (size_q[sidx] >= req);

	assign stat.scan_done = (scan_q >= count_q) || (found_q && policy != POL_BEST
		&& policy != POL_WORST);
	assign stat.found = found_q;
	assign stat.exact = size_q[pick_q] == req;
	assign stat.full = count_q >= CW'(MAX_PARTS);
	assign stat.shift_done = cmd.shift_down ? (pos_q + 1'b1 >= count_q)
		: (pos_q <= CW'(pick_q));
	assign stat.idx_bad = fidx >= count_q;
	assign stat.next_free = (CW'(pick_q) + 1'b1 < count_q)
		&& !busy_q[IW'(CW'(pick_q) + 1'b1)];
	assign stat.prev_free = (pick_q != '0) && !busy_q[pick_q - 1'b1];
	assign pick_start = start_q[pick_q];
	assign pick_idx = pick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			count_q <= CW'(1);
			scan_q <= '0;
			pick_q <= '0;
			pos_q <= '0;
			found_q <= 1'b0;
			start_q[0] <= '0;
			size_q[0] <= SIZE_BITS'(TOTAL_RESET);
		end else if (cmd.cfg_reset) begin
			busy_q <= '0;
			count_q <= CW'(1);
			start_q[0] <= '0;
			size_q[0] <= SIZE_BITS'(total);
		end else begin
			if (cmd.start_scan) begin
				scan_q <= '0;
				found_q <= 1'b0;
				pick_q <= item.partition_index[IW-1:0];
				pos_q <= count_q;
			end
			if (cmd.step_scan) begin
				scan_q <= scan_q + 1'b1;
				if (cand) begin
					if (!found_q || (policy == POL_BEST && size_q[sidx] < size_q[pick_q])
						|| (policy == POL_WORST && size_q[sidx] > size_q[pick_q])) begin
						pick_q <= sidx;
					end
					found_q <= 1'b1;
				end
			end
			if (cmd.mark_pick)
				busy_q[pick_q] <= 1'b1;
			if (cmd.clear_busy) begin
				busy_q[pick_q] <= 1'b0;
				pos_q <= CW'(pick_q) + 1'b1;
			end
			if (cmd.shift_up) begin
				if (pos_q > CW'(pick_q)) begin
					start_q[IW'(pos_q)] <= start_q[IW'(pos_q - 1'b1)];
					size_q[IW'(pos_q)] <= size_q[IW'(pos_q - 1'b1)];
					busy_q[IW'(pos_q)] <= busy_q[IW'(pos_q - 1'b1)];
					pos_q <= pos_q - 1'b1;
				end
			end
			if (cmd.finish_split) begin
				count_q <= count_q + 1'b1;
				size_q[pick_q] <= req;
				busy_q[pick_q] <= 1'b1;
				start_q[IW'(CW'(pick_q) + 1'b1)] <= start_q[pick_q] + req;
				size_q[IW'(CW'(pick_q) + 1'b1)] <= size_q[IW'(CW'(pick_q) + 1'b1)] - req;
				busy_q[IW'(CW'(pick_q) + 1'b1)] <= 1'b0;
			end
			if (cmd.merge_next) begin
				size_q[pick_q] <= size_q[pick_q] + size_q[IW'(CW'(pick_q) + 1'b1)];
				pos_q <= CW'(pick_q) + 1'b1;
			end
			if (cmd.merge_prev) begin
				size_q[pick_q - 1'b1] <= size_q[pick_q - 1'b1] + size_q[pick_q];
				pos_q <= CW'(pick_q);
			end
			if (cmd.shift_down) begin
				if (pos_q + 1'b1 < count_q) begin
					start_q[IW'(pos_q)] <= start_q[IW'(pos_q + 1'b1)];
					size_q[IW'(pos_q)] <= size_q[IW'(pos_q + 1'b1)];
					busy_q[IW'(pos_q)] <= busy_q[IW'(pos_q + 1'b1)];
					pos_q <= pos_q + 1'b1;
				end else begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

endmodule

// File: design/pfa_control.sv
module pfa_control (
	input logic clk,
	input logic arst_n,
	input logic in_go,
	input logic op_free,
	input logic req_zero,
	input pfa_pkg::dp_stat_t stat,
	input logic out_taken,
	output pfa_pkg::dp_cmd_t cmd,
	output logic busy,
	output logic out_valid,
	output logic [2:0] status,
	output logic ok_alloc
);
	import pfa_pkg::*;

	state_t state_q, state_d;
	logic [2:0] status_q, status_d;
	logic ok_q, ok_d;

	assign busy = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;
	assign status = status_q;
	assign ok_alloc = ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= '0;
			ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			status_q <= status_d;
			ok_q <= ok_d;
		end
	end

	always_comb begin
		state_d = state_q;
		status_d = status_q;
		ok_d = ok_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_go) begin
					cmd.start_scan = 1'b1;
					ok_d = 1'b0;
					status_d = ST_OK;
					if (op_free)
						state_d = S_FREE_CHK;
					else if (req_zero) begin
						status_d = ST_BAD_SIZE;
						state_d = S_OUT;
					end else
						state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_done)
					state_d = S_DECIDE;
				else
					cmd.step_scan = 1'b1;
			end
			S_DECIDE: begin
				state_d = S_OUT;
				if (!stat.found)
					status_d = ST_NO_SPACE;
				else if (stat.exact) begin
					cmd.mark_pick = 1'b1;
					ok_d = 1'b1;
				end else if (stat.full)
					status_d = ST_TABLE_FULL;
				else begin
					cmd.shift_up = 1'b1;
					state_d = S_SHIFT_UP;
				end
			end
			S_SHIFT_UP: begin
				cmd.shift_up = 1'b1;
				if (stat.shift_done) begin
					cmd.shift_up = 1'b0;
					state_d = S_SPLIT;
				end
			end
			S_SPLIT: begin
				cmd.finish_split = 1'b1;
				ok_d = 1'b1;
				state_d = S_OUT;
			end
			S_FREE_CHK: begin
				if (stat.idx_bad) begin
					status_d = ST_BAD_INDEX;
					state_d = S_OUT;
				end else begin
					cmd.clear_busy = 1'b1;
					state_d = S_MERGE_NEXT;
				end
			end
			S_MERGE_NEXT: begin
				if (stat.next_free) begin
					cmd.merge_next = 1'b1;
					state_d = S_SHIFT_DN1;
				end else
					state_d = S_MERGE_PREV_CHK;
			end
			S_SHIFT_DN1: begin
				cmd.shift_down = 1'b1;
				if (stat.shift_done)
					state_d = S_MERGE_PREV_CHK;
			end
			S_MERGE_PREV_CHK: begin
				if (stat.prev_free) begin
					cmd.merge_prev = 1'b1;
					state_d = S_SHIFT_DN2;
				end else
					state_d = S_OUT;
			end
			S_SHIFT_DN2: begin
				cmd.shift_down = 1'b1;
				if (stat.shift_done)
					state_d = S_OUT;
			end
			S_OUT: begin
				if (out_taken)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: design/partition_fit_allocator.sv
// partition fit allocator
// in channel: in_valid/in_ready carry an allocate or free request (in_data)
// out channel: out_valid/out_ready carry one result per request (out_data)
// cfg channel: cfg_valid/cfg_ready write fit_policy (index 0) or total_size
//   (index 1); writing total_size resets the table to one free partition
// one request at a time: in_ready is high only while the block is idle and no
//   cfg write is offered; the next request is taken from the cycle after the
//   result transfer
// allocate: a sequential scan of the table entries, then a decide step; a
//   split first moves the entries above the pick up; a zero size skips the scan
// free: a bad index skips the merges; otherwise the entry is freed and, for
//   each merge with the next or previous entry, entries are moved down one by one
// the worst-case run time is set by the sequential scan and the
//   one-entry-per-cycle table shift
// after reset the table holds one free partition of 640 KB at address 0 and
//   first fit is selected
// a stalled receiver sees the result held steady on out_data; no new request
//   is taken until it is transferred
module partition_fit_allocator #(
	parameter int MAX_PARTS = pfa_pkg::MAX_PARTS_DEF,
	parameter int SIZE_BITS = pfa_pkg::SIZE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input pfa_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output pfa_pkg::out_item_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [15:0] cfg_data
);
	import pfa_pkg::*;

	logic [1:0] policy_q;
	logic [15:0] total_q;
	in_item_t item_q;
	in_item_t dp_item;
	dp_cmd_t cmd, cmd_c;
	dp_stat_t stat;
	logic busy, ok_alloc, cfg_go;
	logic [2:0] status;
	logic [SIZE_BITS-1:0] pick_start;
	logic [$clog2(MAX_PARTS)-1:0] pick_idx;

	assign in_ready = !busy && !cfg_valid;
	assign cfg_ready = !busy;
	assign cfg_go = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIRST;
			total_q <= 16'(TOTAL_RESET);
		end else if (cfg_go) begin
			if (cfg_index == REG_POLICY)
				policy_q <= cfg_data[1:0];
			else
				total_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_q <= in_data;
	end

	assign dp_item = (in_valid && in_ready) ? in_data : item_q;

	always_comb begin
		cmd = cmd_c;
		cmd.cfg_reset = cfg_go && cfg_index == REG_TOTAL;
	end

	pfa_control u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_go(in_valid && in_ready),
		.op_free(in_data.operation == OP_FREE),
		.req_zero(in_data.request_size == '0),
		.stat(stat),
		.out_taken(out_ready),
		.cmd(cmd_c),
		.busy(busy),
		.out_valid(out_valid),
		.status(status),
		.ok_alloc(ok_alloc)
	);

	pfa_datapath #(.MAX_PARTS(MAX_PARTS), .SIZE_BITS(SIZE_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.item(dp_item),
		.policy(policy_q),
		.total(cfg_data),
		.stat(stat),
		.pick_start(pick_start),
		.pick_idx(pick_idx)
	);

	assign out_data.status = status;
	assign out_data.start_address = ok_alloc ? 16'(pick_start) : '0;
	assign out_data.placed_index = ok_alloc ? 4'(pick_idx) : '0;

endmodule

// File: design/pfa_checker.sv
module pfa_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input pfa_pkg::out_item_t out_data,
	input logic cfg_ready
);
	import pfa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while result pending");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_TABLE_FULL)
		else $error("status out of range");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.start_address == '0
		&& out_data.placed_index == '0)
		else $error("failed request shows placement");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> cfg_ready)
		else $error("cfg and input readiness disagree");

endmodule

bind partition_fit_allocator pfa_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data),
	.cfg_ready(cfg_ready)
);
